// ===== rtl/indexed_list_engine_assert.svh =====
// Assertion helpers for the list engine; expect clk and rst_n in scope.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ile_pkg.sv =====
package ile_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 5;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_HANDLE_BITS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT = 3'd0,
    OP_REMOVE_AT = 3'd1,
    OP_REMOVE_VAL = 3'd2,
    OP_GET_AT    = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // Broadcast command seen by every cell; enables already include the range checks.
  typedef struct packed {
    logic ins_en;
    logic rmat_en;
    logic rmval_en;
    logic get_en;
  } cell_cmd_t;

endpackage

// ===== rtl/ile_in_if.sv =====
interface ile_in_if
  import ile_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    position;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, operation, position, handle, input ready);
  modport sink (input valid, operation, position, handle, output ready);
endinterface

// ===== rtl/ile_out_if.sv =====
interface ile_out_if
  import ile_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] read_value;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, ok, read_value, count, input ready);
  modport sink (input valid, ok, read_value, count, output ready);
endinterface

// ===== rtl/ile_cell.sv =====
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int PW          = 5,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  cell_cmd_t              cmd,
  input  logic [PW-1:0]          pos,
  input  logic [PW-1:0]          fill,
  input  logic [HANDLE_BITS-1:0] key,
  input  logic [HANDLE_BITS-1:0] left_val,
  input  logic [HANDLE_BITS-1:0] right_val,
  input  logic                   seen_in,
  output logic                   seen_out,
  input  logic [HANDLE_BITS-1:0] rd_in,
  output logic [HANDLE_BITS-1:0] rd_out,
  output logic [HANDLE_BITS-1:0] val_out
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [HANDLE_BITS-1:0] val_r;
  logic [HANDLE_BITS-1:0] val_nxt;
  logic                   live;
  logic                   match;

  assign live     = MY_IDX < fill;
  assign match    = cmd.rmval_en && live && (val_r == key);
  assign seen_out = seen_in | match;
  assign rd_out   = rd_in | ((cmd.get_en && pos == MY_IDX) ? val_r : '0);
  assign val_out  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins_en) begin
      if (MY_IDX == pos) begin
        val_nxt = key;
      end else if (MY_IDX > pos) begin
        val_nxt = left_val;
      end
    end else if (cmd.rmat_en && MY_IDX >= pos) begin
      val_nxt = right_val;
    end else if (cmd.rmval_en && seen_out) begin
      // close the gap from the first match upward
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/indexed_list_engine.sv =====
// Indexed list engine: an ordered list of up to CAPACITY handles kept in a
// row of cells, one entry per cell, each shifting to its neighbor.
// Input channel in_req carries one request: operation (insert at, remove at,
// remove value, get at, clear), position and handle. Output channel out_rsp
// returns exactly one result per request: ok, read_value and the new count.
// Latency: a request accepted at one edge shows its result at out_rsp in the
// next cycle. Throughput: one request per cycle; every cell compares and
// shifts in the same cycle, and the first-match flag for remove value runs
// along the row of cells within that cycle.
// The result sits in an output register; a new request is taken while that
// register is empty or being drained in the same cycle, so a stalled
// receiver holds off the input after one pending result.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared, since only live positions are read.
`include "indexed_list_engine_assert.svh"

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input logic      clk,
  input logic      rst_n,
  ile_in_if.sink   in_req,
  ile_out_if.source out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [CW-1:0]          fill_r;
  logic [CW-1:0]          fill_nxt;
  logic                   out_valid_r;
  logic                   ok_r;
  logic                   ok_nxt;
  logic [HANDLE_W-1:0]    rd_r;
  logic [COUNT_W-1:0]     count_r;

  logic                   accept;
  op_t                    op;
  logic [PW-1:0]          pos;
  logic [PW-1:0]          fill_p;
  logic [HANDLE_BITS-1:0] key;
  cell_cmd_t              cmd;
  logic                   ins_ok;
  logic                   rmat_ok;
  logic                   get_ok;
  logic                   rmval_ok;

  logic [HANDLE_BITS-1:0] vals [CAPACITY];
  logic [CAPACITY:0]      seen;
  logic [HANDLE_BITS-1:0] rd   [CAPACITY+1];

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign op     = op_t'(in_req.operation);
  assign pos    = PW'(in_req.position);
  assign fill_p = PW'(fill_r);
  assign key    = HANDLE_BITS'(in_req.handle);

  assign ins_ok  = (op == OP_INSERT_AT) && (pos <= fill_p) && (fill_p < CAP_P);
  assign rmat_ok = (op == OP_REMOVE_AT) && (pos < fill_p);
  assign get_ok  = (op == OP_GET_AT) && (pos < fill_p);

  always_comb begin
    cmd          = '0;
    cmd.ins_en   = accept && ins_ok;
    cmd.rmat_en  = accept && rmat_ok;
    cmd.rmval_en = accept && (op == OP_REMOVE_VAL) && (key != '0);
    cmd.get_en   = accept && get_ok;
  end

  assign seen[0] = 1'b0;
  assign rd[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] left_v;
    logic [HANDLE_BITS-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = key;
    end else begin : g_mid
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = vals[i];
    end else begin : g_body
      assign right_v = vals[i+1];
    end

    ile_cell #(
      .IDX         (i),
      .PW          (PW),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos),
      .fill      (fill_p),
      .key       (key),
      .left_val  (left_v),
      .right_val (right_v),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .rd_in     (rd[i]),
      .rd_out    (rd[i+1]),
      .val_out   (vals[i])
    );
  end

  assign rmval_ok = cmd.rmval_en && seen[CAPACITY];

  always_comb begin
    fill_nxt = fill_r;
    ok_nxt   = 1'b0;
    case (op)
      OP_INSERT_AT: begin
        ok_nxt = ins_ok;
        if (ins_ok) fill_nxt = fill_r + CW'(1);
      end
      OP_REMOVE_AT: begin
        ok_nxt = rmat_ok;
        if (rmat_ok) fill_nxt = fill_r - CW'(1);
      end
      OP_REMOVE_VAL: begin
        ok_nxt = rmval_ok;
        if (rmval_ok) fill_nxt = fill_r - CW'(1);
      end
      OP_GET_AT: begin
        ok_nxt = get_ok;
      end
      OP_CLEAR: begin
        ok_nxt   = 1'b1;
        fill_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r    <= ok_nxt;
      rd_r    <= HANDLE_W'(rd[CAPACITY]);
      count_r <= COUNT_W'(fill_nxt);
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.ok         = ok_r;
  assign out_rsp.read_value = rd_r;
  assign out_rsp.count      = count_r;

  `ILE_ASSERT_NOW(a_fill_cap, 1'b1, fill_r <= CW'(CAPACITY), "fill exceeds capacity")
  `ILE_ASSERT_NEXT(a_count_fill, accept, count_r == COUNT_W'(fill_r), "count disagrees with fill")
  `ILE_ASSERT_NEXT(a_clear, accept && op == OP_CLEAR, ok_r && fill_r == '0, "clear did not empty")
  `ILE_ASSERT_NEXT(a_fail_hold, accept && !ok_nxt, $stable(fill_r), "rejected request moved fill")
  `ILE_ASSERT_NEXT(a_rd_zero, accept && op != OP_GET_AT, rd_r == '0, "read value on non-get")

endmodule
